// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the source text tokenizer: transaction
// structs, token kinds, punctuation codes, lexer modes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    // default width of the byte position counter
    localparam int OFFSET_BITS_DEFAULT = 32;

    // results a single byte can cause
    localparam int MAX_RESULTS = 3;

    // token kinds
    localparam logic [2:0] K_IDENT  = 3'd0;
    localparam logic [2:0] K_INT    = 3'd1;
    localparam logic [2:0] K_CHAR   = 3'd2;
    localparam logic [2:0] K_STRING = 3'd3;
    localparam logic [2:0] K_PUNCT  = 3'd4;
    localparam logic [2:0] K_END    = 3'd5;
    localparam logic [2:0] K_ERROR  = 3'd6;

    // punctuation codes
    localparam logic [2:0] P_SEMI   = 3'd0;
    localparam logic [2:0] P_COMMA  = 3'd1;
    localparam logic [2:0] P_EQUAL  = 3'd2;
    localparam logic [2:0] P_DOT    = 3'd3;
    localparam logic [2:0] P_COLON  = 3'd4;
    localparam logic [2:0] P_LBRACK = 3'd5;
    localparam logic [2:0] P_RBRACK = 3'd6;
    localparam logic [2:0] P_NONE   = 3'd0;

    // character codes
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;
    localparam logic [7:0] CH_LOWER_R    = 8'h72;
    localparam logic [7:0] CH_LOWER_T    = 8'h74;

    // lexer modes
    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_SLASH   = 4'd1,
        M_LINE    = 4'd2,
        M_BLOCK   = 4'd3,
        M_IDENT   = 4'd4,
        M_NUMBER  = 4'd5,
        M_LITERAL = 4'd6,
        M_ESCAPE  = 4'd7
    } lex_mode_t;

    // input transaction
    typedef struct packed {
        logic [7:0] source_byte;
        logic       final_byte;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [2:0]  punct_code;
        logic [31:0] token_offset;
        logic [31:0] token_length;
        logic        run_last;
    } out_item_t;

    // results of one byte, handed from lexer to result queue
    typedef struct packed {
        out_item_t [MAX_RESULTS-1:0] items;
        logic [1:0]                  count;
    } res_bundle_t;

endpackage

`default_nettype wire

// ===== rtl/stt_lex_core.sv =====
// ----------------------------------------------------------------------------
// stt_lex_core
// Lexer state and single-pass step logic: classifies the held byte against
// the current mode and produces up to three results plus the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_lex_core #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire stt_pkg::in_item_t   item,
    output stt_pkg::res_bundle_t     bundle
);
    import stt_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);

    // character classes
    function automatic logic is_letter(input logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_LOWER_A && b <= CH_LOWER_Z) || b == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic good_escape(input logic [7:0] b);
        return b == CH_ZERO || b == CH_LOWER_N || b == CH_LOWER_R || b == CH_LOWER_T ||
               b == CH_BACKSLASH || b == CH_QUOTE || b == CH_DQUOTE;
    endfunction

    // low 32 bits of a position value, zero extended when narrower
    function automatic logic [31:0] to32(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+31:0] w;
        w = {32'b0, v};
        return w[31:0];
    endfunction

    function automatic out_item_t make_res(input logic [2:0] kind, input logic [2:0] pc,
                                           input logic [31:0] off, input logic [31:0] len);
        out_item_t r;
        r.token_kind   = kind;
        r.punct_code   = pc;
        r.token_offset = off;
        r.token_length = len;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // state registers
    lex_mode_t              mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic                   dq_reg, dq_next;
    logic                   star_reg, star_next;
    logic                   drain_reg, drain_next;

    logic [7:0]             b;
    logic                   fin;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   err;
    logic                   do_start;
    out_item_t [MAX_RESULTS-1:0] res;
    logic [1:0]             cnt;

    assign b       = item.source_byte;
    assign fin     = item.final_byte;
    assign pos_inc = pos_reg + POS_ONE;

    // one step of the lexer on the held byte
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        dq_next    = dq_reg;
        star_next  = star_reg;
        err        = 1'b0;
        do_start   = 1'b0;
        cnt        = 2'd0;
        res        = '0;

        if (!drain_reg)
        begin
            // continue the token in progress
            case (mode_reg)
                M_SLASH:
                begin
                    if (b == CH_SLASH)
                    begin
                        mode_next = M_LINE;
                    end
                    else if (b == CH_STAR)
                    begin
                        mode_next = M_BLOCK;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        err = 1'b1;
                        res[cnt] = make_res(K_ERROR, P_NONE, to32(start_reg), 32'd1);
                        cnt = cnt + 2'd1;
                    end
                end
                M_LINE:
                begin
                    if (b == CH_LF)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_BLOCK:
                begin
                    if (star_reg && b == CH_SLASH)
                    begin
                        mode_next = M_IDLE;
                        star_next = 1'b0;
                    end
                    else
                    begin
                        star_next = (b == CH_STAR);
                    end
                end
                M_IDENT, M_NUMBER:
                begin
                    if (!(is_digit(b) || (mode_reg == M_IDENT && is_letter(b))))
                    begin
                        res[cnt] = make_res((mode_reg == M_IDENT) ? K_IDENT : K_INT, P_NONE,
                                            to32(start_reg), to32(pos_reg - start_reg));
                        cnt = cnt + 2'd1;
                        mode_next = M_IDLE;
                        do_start  = 1'b1;
                    end
                end
                M_LITERAL:
                begin
                    if (b == CH_LF || b == CH_CR)
                    begin
                        err = 1'b1;
                        res[cnt] = make_res(K_ERROR, P_NONE, to32(start_reg),
                                            to32(pos_reg - start_reg));
                        cnt = cnt + 2'd1;
                    end
                    else if (b == (dq_reg ? CH_DQUOTE : CH_QUOTE))
                    begin
                        res[cnt] = make_res(dq_reg ? K_STRING : K_CHAR, P_NONE,
                                            to32(start_reg), to32(pos_inc - start_reg));
                        cnt = cnt + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (b == CH_BACKSLASH)
                    begin
                        mode_next = M_ESCAPE;
                    end
                end
                M_ESCAPE:
                begin
                    if (good_escape(b))
                    begin
                        mode_next = M_LITERAL;
                    end
                    else
                    begin
                        err = 1'b1;
                        res[cnt] = make_res(K_ERROR, P_NONE, to32(pos_reg - POS_ONE), 32'd2);
                        cnt = cnt + 2'd1;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                    do_start  = 1'b1;
                end
            endcase

            // byte seen between tokens
            if (do_start)
            begin
                if (is_space(b))
                begin
                    mode_next = M_IDLE;
                end
                else if (b == CH_SLASH)
                begin
                    mode_next  = M_SLASH;
                    start_next = pos_reg;
                end
                else if (is_letter(b))
                begin
                    mode_next  = M_IDENT;
                    start_next = pos_reg;
                end
                else if (is_digit(b))
                begin
                    mode_next  = M_NUMBER;
                    start_next = pos_reg;
                end
                else if (b == CH_QUOTE || b == CH_DQUOTE)
                begin
                    mode_next  = M_LITERAL;
                    start_next = pos_reg;
                    dq_next    = (b == CH_DQUOTE);
                end
                else
                begin
                    case (b)
                        CH_SEMI:   res[cnt] = make_res(K_PUNCT, P_SEMI, to32(pos_reg), 32'd1);
                        CH_COMMA:  res[cnt] = make_res(K_PUNCT, P_COMMA, to32(pos_reg), 32'd1);
                        CH_EQUAL:  res[cnt] = make_res(K_PUNCT, P_EQUAL, to32(pos_reg), 32'd1);
                        CH_DOT:    res[cnt] = make_res(K_PUNCT, P_DOT, to32(pos_reg), 32'd1);
                        CH_COLON:  res[cnt] = make_res(K_PUNCT, P_COLON, to32(pos_reg), 32'd1);
                        CH_LBRACK: res[cnt] = make_res(K_PUNCT, P_LBRACK, to32(pos_reg), 32'd1);
                        CH_RBRACK: res[cnt] = make_res(K_PUNCT, P_RBRACK, to32(pos_reg), 32'd1);
                        default:
                        begin
                            err = 1'b1;
                            res[cnt] = make_res(K_ERROR, P_NONE, to32(pos_reg), 32'd1);
                        end
                    endcase
                    cnt = cnt + 2'd1;
                end
            end

            // close out the source on the final byte
            if (fin && !err)
            begin
                case (mode_next)
                    M_IDENT, M_NUMBER:
                    begin
                        res[cnt] = make_res((mode_next == M_IDENT) ? K_IDENT : K_INT, P_NONE,
                                            to32(start_next), to32(pos_inc - start_next));
                        cnt = cnt + 2'd1;
                    end
                    M_SLASH:
                    begin
                        err = 1'b1;
                        res[cnt] = make_res(K_ERROR, P_NONE, to32(start_next), 32'd1);
                        cnt = cnt + 2'd1;
                    end
                    M_ESCAPE:
                    begin
                        err = 1'b1;
                        res[cnt] = make_res(K_ERROR, P_NONE, to32(pos_reg), 32'd1);
                        cnt = cnt + 2'd1;
                    end
                    M_LITERAL, M_BLOCK:
                    begin
                        err = 1'b1;
                        res[cnt] = make_res(K_ERROR, P_NONE, to32(start_next),
                                            to32(pos_inc - start_next));
                        cnt = cnt + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
                if (!err)
                begin
                    res[cnt] = make_res(K_END, P_NONE, to32(pos_inc), 32'd0);
                    cnt = cnt + 2'd1;
                end
            end

            // flag the last result of this byte
            if (cnt != 2'd0)
            begin
                res[cnt - 2'd1].run_last = 1'b1;
            end
        end
    end

    // next state when the byte is consumed
    always_comb
    begin
        pos_next   = pos_reg;
        drain_next = drain_reg;
        if (fin)
        begin
            pos_next   = '0;
            drain_next = 1'b0;
        end
        else
        begin
            pos_next = pos_inc;
            if (err)
            begin
                drain_next = 1'b1;
            end
        end
    end

    assign bundle.items = res;
    assign bundle.count = cnt;

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            dq_reg    <= 1'b0;
            star_reg  <= 1'b0;
            drain_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            drain_reg <= drain_next;
            if (fin)
            begin
                mode_reg  <= M_IDLE;
                start_reg <= '0;
                dq_reg    <= 1'b0;
                star_reg  <= 1'b0;
            end
            else if (!drain_reg)
            begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                dq_reg    <= dq_next;
                star_reg  <= star_next;
            end
        end
    end

    // draining bytes cause no results
    a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> cnt == 2'd0)
        else $error("result produced while draining after an error");

    // final byte brings the lexer back to its reset state
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin |=> pos_reg == '0 && !drain_reg && mode_reg == M_IDLE)
        else $error("lexer state not cleared after final byte");

    // every non-final byte advances the position by one
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !fin |=> pos_reg == $past(pos_inc))
        else $error("byte position did not advance");

endmodule

`default_nettype wire

// ===== rtl/stt_result_queue.sv =====
// ----------------------------------------------------------------------------
// stt_result_queue
// Holds the results of one byte and hands them out one transaction per
// cycle while tok_stall is low; reports when it can take the next byte's results.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_result_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire stt_pkg::res_bundle_t bundle,
    output logic                      free,
    output logic                      tok_valid,
    input  wire logic                 tok_stall,
    output stt_pkg::out_item_t        tok_item
);
    import stt_pkg::*;

    out_item_t [MAX_RESULTS-1:0] slot_reg;
    logic [1:0]                  count_reg;
    logic [1:0]                  rd_reg;
    logic                        take;

    assign tok_valid = (count_reg != 2'd0);
    assign tok_item  = slot_reg[rd_reg];
    assign take      = tok_valid && !tok_stall;

    // empty now, or emptied by the transaction taken this cycle
    assign free = (count_reg == 2'd0) || (count_reg == 2'd1 && !tok_stall);

    // result slots need no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle.items;
        end
    end

    // occupancy and read pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= bundle.count;
            rd_reg    <= 2'd0;
        end
        else if (take)
        begin
            count_reg <= count_reg - 2'd1;
            rd_reg    <= rd_reg + 2'd1;
        end
    end

    // the last pending result carries the run_last flag
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> tok_item.run_last == (count_reg == 2'd1))
        else $error("run_last does not match queue occupancy");

    // pending results never overrun the slots
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, rd_reg} + {1'b0, count_reg} <= 3'd3)
        else $error("read pointer beyond stored results");

    // results are never loaded over pending ones
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load && bundle.count != 2'd0 |-> free)
        else $error("results loaded while queue busy");

endmodule

`default_nettype wire

// ===== rtl/source_text_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming lexer: one source byte per transaction in, tokens out.
// ----------------------------------------------------------------------------
// path: an accepted byte waits in the input register, then its results enter
//   the result queue, from which the output takes them
// throughput: one byte per cycle while the input is not stalled; the results of
//   a byte leave one at a time, and the next byte with results waits behind them
// reset: rst_n clears the lexer to idle, position zero, queues empty
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_core #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire stt_pkg::in_item_t  src_item,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output stt_pkg::out_item_t      tok_item
);
    import stt_pkg::*;

    in_item_t    in_item_reg;
    logic        in_full_reg, in_full_next;
    res_bundle_t bundle;
    logic        q_free;
    logic        q_load;
    logic        fire;
    logic        accept;

    // the held byte moves on when its results fit the queue
    assign fire      = in_full_reg && (bundle.count == 2'd0 || q_free);
    assign src_stall = in_full_reg && !fire;
    assign accept    = src_valid && !src_stall;

    // only a byte with results touches the queue
    assign q_load    = fire && bundle.count != 2'd0;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (fire)
        begin
            in_full_next = 1'b0;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= src_item;
        end
    end

    stt_lex_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lex (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    stt_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (q_load),
        .bundle    (bundle),
        .free      (q_free),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    // a stalled input only ever waits behind a held byte
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> in_full_reg && bundle.count != 2'd0 && tok_valid)
        else $error("input stalled without a pending byte");

    // a byte with results is released only into a free queue
    a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire && bundle.count != 2'd0 |=> tok_valid)
        else $error("released byte produced no pending result");

    // an accepted byte is held until consumed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_full_reg)
        else $error("accepted byte lost from input register");

endmodule

`default_nettype wire

// ===== tb/source_text_tokenizer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_test
// Self-checking bench for the streaming tokenizer. Source texts are sent one
// byte per transaction; a local lexer model predicts the tokens of each
// accepted byte, and every token leaving the block is compared field by
// field with the oldest prediction. Directed sources cover each token kind,
// punctuation mark and error case; random sources follow, under three
// idling profiles, plus a long output hold-off and a drained pause.
// ----------------------------------------------------------------------------

module source_text_tokenizer_core_test;

    import stt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       src_valid = 1'b0;
    logic       src_stall;
    in_item_t   src_item  = '0;
    logic       tok_valid;
    logic       tok_stall = 1'b0;
    out_item_t  tok_item;

    // lexer model state
    lex_mode_t   lx_mode;
    logic [31:0] lx_pos;
    logic [31:0] lx_start;
    bit          lx_dquote;
    bit          lx_star;
    bit          lx_drain;

    out_item_t   step_tokens[$];
    out_item_t   expected_tokens[$];
    logic [7:0]  source_buf[$];

    int src_gap_pct   = 23;
    int tok_stall_pct = 60;
    int hold_left     = 0;
    int bytes_sent    = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    source_text_tokenizer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL source_text_tokenizer_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic bit is_letter(input logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_LOWER_A && b <= CH_LOWER_Z) || b == CH_UNDERSCORE;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic bit good_escape(input logic [7:0] b);
        return b == CH_ZERO || b == CH_LOWER_N || b == CH_LOWER_R || b == CH_LOWER_T ||
               b == CH_BACKSLASH || b == CH_QUOTE || b == CH_DQUOTE;
    endfunction

    function automatic bit punct_of(input logic [7:0] b, output logic [2:0] pc);
        pc = P_NONE;
        case (b)
            CH_SEMI:   pc = P_SEMI;
            CH_COMMA:  pc = P_COMMA;
            CH_EQUAL:  pc = P_EQUAL;
            CH_DOT:    pc = P_DOT;
            CH_COLON:  pc = P_COLON;
            CH_LBRACK: pc = P_LBRACK;
            CH_RBRACK: pc = P_RBRACK;
            default:   return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------------
    function automatic void lexer_clear();
        lx_mode   = M_IDLE;
        lx_pos    = '0;
        lx_start  = '0;
        lx_dquote = 1'b0;
        lx_star   = 1'b0;
        lx_drain  = 1'b0;
    endfunction

    function automatic void emit(input logic [2:0] kind, input logic [2:0] pc,
                                 input logic [31:0] off, input logic [31:0] len);
        out_item_t r;
        r.token_kind   = kind;
        r.punct_code   = pc;
        r.token_offset = off;
        r.token_length = len;
        r.run_last     = 1'b0;
        step_tokens = {step_tokens, r};
    endfunction

    // byte seen between tokens; returns 1 on an error
    function automatic bit open_token(input logic [7:0] b, input logic [31:0] p);
        logic [2:0] pc;
        if (is_space(b))
            return 1'b0;
        if (b == CH_SLASH || is_letter(b) || is_digit(b) || b == CH_QUOTE || b == CH_DQUOTE)
        begin
            lx_start = p;
            if (b == CH_SLASH)
                lx_mode = M_SLASH;
            else if (is_letter(b))
                lx_mode = M_IDENT;
            else if (is_digit(b))
                lx_mode = M_NUMBER;
            else
            begin
                lx_mode   = M_LITERAL;
                lx_dquote = (b == CH_DQUOTE);
            end
            return 1'b0;
        end
        if (punct_of(b, pc))
        begin
            emit(K_PUNCT, pc, p, 32'd1);
            return 1'b0;
        end
        emit(K_ERROR, P_NONE, p, 32'd1);
        return 1'b1;
    endfunction

    // tokens caused by one accepted byte, appended to the expected queue
    function automatic void lex_byte(input in_item_t it);
        logic [7:0]  b;
        logic [31:0] p;
        logic [31:0] nxt;
        logic [2:0]  kind;
        bit          fin;
        bit          err;
        b   = it.source_byte;
        fin = it.final_byte;
        p   = lx_pos;
        nxt = lx_pos + 32'd1;
        err = 1'b0;
        step_tokens.delete();

        // dropping bytes after an error
        if (lx_drain)
        begin
            if (fin)
                lexer_clear();
            else
                lx_pos = nxt;
            return;
        end

        case (lx_mode)
            M_SLASH:
            begin
                if (b == CH_SLASH)
                    lx_mode = M_LINE;
                else if (b == CH_STAR)
                begin
                    lx_mode = M_BLOCK;
                    lx_star = 1'b0;
                end
                else
                begin
                    err = 1'b1;
                    emit(K_ERROR, P_NONE, lx_start, 32'd1);
                end
            end
            M_LINE:
            begin
                if (b == CH_LF)
                    lx_mode = M_IDLE;
            end
            M_BLOCK:
            begin
                if (lx_star && b == CH_SLASH)
                begin
                    lx_mode = M_IDLE;
                    lx_star = 1'b0;
                end
                else
                    lx_star = (b == CH_STAR);
            end
            M_IDENT, M_NUMBER:
            begin
                if (!(is_digit(b) || (lx_mode == M_IDENT && is_letter(b))))
                begin
                    kind = (lx_mode == M_IDENT) ? K_IDENT : K_INT;
                    emit(kind, P_NONE, lx_start, p - lx_start);
                    lx_mode = M_IDLE;
                    err = open_token(b, p);
                end
            end
            M_LITERAL:
            begin
                if (b == CH_LF || b == CH_CR)
                begin
                    err = 1'b1;
                    emit(K_ERROR, P_NONE, lx_start, p - lx_start);
                end
                else if (b == (lx_dquote ? CH_DQUOTE : CH_QUOTE))
                begin
                    kind = lx_dquote ? K_STRING : K_CHAR;
                    emit(kind, P_NONE, lx_start, nxt - lx_start);
                    lx_mode = M_IDLE;
                end
                else if (b == CH_BACKSLASH)
                    lx_mode = M_ESCAPE;
            end
            M_ESCAPE:
            begin
                if (good_escape(b))
                    lx_mode = M_LITERAL;
                else
                begin
                    err = 1'b1;
                    emit(K_ERROR, P_NONE, p - 32'd1, 32'd2);
                end
            end
            default:
            begin
                lx_mode = M_IDLE;
                err = open_token(b, p);
            end
        endcase

        // end of source: close or flag whatever is open, then the end token
        if (fin && !err)
        begin
            case (lx_mode)
                M_IDENT, M_NUMBER:
                begin
                    kind = (lx_mode == M_IDENT) ? K_IDENT : K_INT;
                    emit(kind, P_NONE, lx_start, nxt - lx_start);
                end
                M_SLASH:
                begin
                    err = 1'b1;
                    emit(K_ERROR, P_NONE, lx_start, 32'd1);
                end
                M_ESCAPE:
                begin
                    err = 1'b1;
                    emit(K_ERROR, P_NONE, p, 32'd1);
                end
                M_LITERAL, M_BLOCK:
                begin
                    err = 1'b1;
                    emit(K_ERROR, P_NONE, lx_start, nxt - lx_start);
                end
                default:
                    ;
            endcase
            if (!err)
                emit(K_END, P_NONE, nxt, 32'd0);
        end

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].run_last = 1'b1;
        for (int i = 0; i < step_tokens.size(); i++)
            expected_tokens = {expected_tokens, step_tokens[i]};

        if (fin)
            lexer_clear();
        else
        begin
            lx_pos = nxt;
            if (err)
                lx_drain = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // token checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch in %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want, cycle_count);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && tok_valid && !tok_stall)
        begin
            if (expected_tokens.size() == 0)
                report_mismatch("token kind, nothing expected",
                                32'(tok_item.token_kind), 32'd0);
            else
            begin
                want = expected_tokens.pop_front();
                if (tok_item.token_kind !== want.token_kind)
                    report_mismatch("token_kind", 32'(tok_item.token_kind),
                                    32'(want.token_kind));
                if (tok_item.punct_code !== want.punct_code)
                    report_mismatch("punct_code", 32'(tok_item.punct_code),
                                    32'(want.punct_code));
                if (tok_item.token_offset !== want.token_offset)
                    report_mismatch("token_offset", tok_item.token_offset,
                                    want.token_offset);
                if (tok_item.token_length !== want.token_length)
                    report_mismatch("token_length", tok_item.token_length,
                                    want.token_length);
                if (tok_item.run_last !== want.run_last)
                    report_mismatch("run_last", 32'(tok_item.run_last),
                                    32'(want.run_last));
            end
        end
    end

    // output stall: long hold-off when requested, otherwise random
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            tok_stall <= 1'b1;
            hold_left--;
        end
        else
            tok_stall <= ($urandom_range(0, 99) < tok_stall_pct);
    end

    // ------------------------------------------------------------------------
    // byte sending
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit fin);
        in_item_t it;
        it.source_byte = b;
        it.final_byte  = fin;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            @(negedge clk);
            src_valid <= 1'b0;
        end
        @(negedge clk);
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        lex_byte(it);
        bytes_sent++;
    endtask

    task automatic send_source();
        for (int i = 0; i < source_buf.size(); i++)
            send_byte(source_buf[i], i == source_buf.size() - 1);
        source_buf.delete();
    endtask

    // sender goes quiet before waiting, so the last byte is not offered again
    task automatic wait_drained();
        @(negedge clk);
        src_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic void add_byte(input logic [7:0] c);
        source_buf = {source_buf, c};
    endfunction

    function automatic void load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    // ------------------------------------------------------------------------
    // random source text
    // ------------------------------------------------------------------------
    function automatic logic [7:0] word_char(input bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26)
            return CH_UPPER_A + 8'(r);
        if (r < 52)
            return CH_LOWER_A + 8'(r - 26);
        if (r == 52)
            return CH_UNDERSCORE;
        return CH_ZERO + 8'(r - 53);
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 6))
            0:       return CH_SEMI;
            1:       return CH_COMMA;
            2:       return CH_EQUAL;
            3:       return CH_DOT;
            4:       return CH_COLON;
            5:       return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 6))
            0:       return CH_ZERO;
            1:       return CH_LOWER_N;
            2:       return CH_LOWER_R;
            3:       return CH_LOWER_T;
            4:       return CH_BACKSLASH;
            5:       return CH_QUOTE;
            default: return CH_DQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] printable(input logic [7:0] shun);
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == shun || c == CH_BACKSLASH)
            c = 8'($urandom_range(8'h20, 8'h7E));
        return c;
    endfunction

    // literal body: plain characters and valid escapes
    function automatic void add_literal_body(input logic [7:0] close, input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_byte(CH_BACKSLASH);
                add_byte(pick_escape());
            end
            else
                add_byte(printable(close));
        end
    endfunction

    function automatic void add_piece();
        int         r;
        int         n;
        logic [7:0] q;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_QUOTE;
        if (r < 20)
        begin
            // identifier
            add_byte(word_char(1'b1));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                add_byte(word_char(1'b0));
        end
        else if (r < 34)
        begin
            // integer
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (r < 54)
            add_byte(pick_punct());
        else if (r < 70)
        begin
            // char or string literal
            add_byte(q);
            add_literal_body(q, q == CH_QUOTE ? 2 : 4);
            add_byte(q);
        end
        else if (r < 82)
        begin
            // whitespace run
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_byte($urandom_range(0, 1) ? CH_SPACE
                                              : CH_TAB + 8'($urandom_range(0, 4)));
        end
        else if (r < 88)
        begin
            // line comment
            add_byte(CH_SLASH);
            add_byte(CH_SLASH);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
                add_byte(printable(CH_BACKSLASH));
            add_byte(CH_LF);
        end
        else if (r < 95)
        begin
            // block comment, body rich in stars and slashes
            add_byte(CH_SLASH);
            add_byte(CH_STAR);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 2))
                    0:       add_byte(CH_STAR);
                    1:       add_byte(CH_SLASH);
                    default: add_byte(printable(CH_STAR));
                endcase
            end
            add_byte(CH_STAR);
            add_byte(CH_SLASH);
        end
        else if (r < 98)
        begin
            // literal with a bad escape
            add_byte(q);
            add_byte(CH_BACKSLASH);
            c = 8'($urandom_range(0, 255));
            while (good_escape(c))
                c = 8'($urandom_range(0, 255));
            add_byte(c);
        end
        else
        begin
            // literal broken by a line end
            add_byte(q);
            add_literal_body(q, 2);
            add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        end
    endfunction

    function automatic void build_source();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            add_piece();
        // noise byte anywhere
        if ($urandom_range(0, 9) == 0)
            source_buf.insert($urandom_range(0, source_buf.size()),
                              8'($urandom_range(0, 255)));
        // cut short, leaving something open
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, source_buf.size());
            while (source_buf.size() > n)
                void'(source_buf.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every punctuation mark, identifier, integer at the final byte,
    // char and string literals with escapes
    task automatic test_tokens();
        load_text("_Z9;,=.:[]0");
        send_source();
        load_text("'\\''\"\\0\"");
        send_source();
    endtask

    // slash-star-slash does not close, so the comment stays open to the end
    task automatic test_comments();
        load_text("/*/");
        send_source();
    endtask

    task automatic test_errors();
        // lone slash as final byte
        load_text("/");
        send_source();
        // lone slash, followed by a byte that opens no comment
        add_byte(CH_SLASH);
        add_byte(8'h00);
        send_source();
        // line end inside a literal
        add_byte(CH_QUOTE);
        add_byte(CH_LF);
        send_source();
        // bad escape
        load_text("'\\q");
        send_source();
        // backslash as final byte
        load_text("\"\\");
        send_source();
        // literal left open
        load_text("\"");
        send_source();
        // byte that starts nothing
        add_byte(8'hFF);
        send_source();
    endtask

    // output held off while bytes keep coming, so the input must stall
    task automatic test_backpressure();
        src_gap_pct   = 0;
        tok_stall_pct = 0;
        hold_left     = 150;
        for (int i = 0; i < 64; i++)
            add_byte(pick_punct());
        send_source();
        wait_drained();
    endtask

    // sender stops mid-source until every token is out
    task automatic test_pause();
        int half;
        src_gap_pct   = 23;
        tok_stall_pct = 60;
        for (int i = 0; i < 6; i++)
            add_piece();
        half = source_buf.size() / 2;
        for (int i = 0; i < half; i++)
            send_byte(source_buf[i], 1'b0);
        wait_drained();
        repeat ($urandom_range(5, 20)) @(posedge clk);
        for (int i = half; i < source_buf.size(); i++)
            send_byte(source_buf[i], i == source_buf.size() - 1);
        source_buf.delete();
    endtask

    task automatic test_random(input int gap_pct, input int stall_pct, input int count);
        int first;
        src_gap_pct   = gap_pct;
        tok_stall_pct = stall_pct;
        first         = bytes_sent;
        while (bytes_sent - first < count)
        begin
            build_source();
            send_source();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        lexer_clear();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_tokens();
        test_comments();
        test_errors();
        test_backpressure();
        test_pause();
        test_random(23, 60, 120);
        test_random(60, 23, 120);
        test_random(0, 0, 120);

        @(negedge clk);
        src_valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS source_text_tokenizer_core");
        else
            $display("FAIL source_text_tokenizer_core");
        $finish;
    end

endmodule
